@@ src/csre_pkg.sv @@
package csre_pkg;

    // Default geometry
    localparam int DEF_SETS      = 64;
    localparam int DEF_WAYS      = 4;
    localparam int DEF_LINE_SIZE = 8;

    // Per-way entry layout: {valid, line address, use count}
    localparam int ADDR_W = 32;
    localparam int USE_W  = 10;
    localparam int ENT_W  = 1 + ADDR_W + USE_W;

    localparam logic [USE_W-1:0] USE_CEIL = 10'd999;

    // Policy register codes
    localparam logic [1:0] POL_FIFO = 2'd0;
    localparam logic [1:0] POL_LFU  = 2'd1;
    localparam logic [1:0] POL_LRU  = 2'd2;

    // Register index
    localparam logic [1:0] REG_POLICY = 2'd0;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ALIGN,
        ST_CALC
    } t_state;

    // Saturating increment of a use counter
    function automatic logic [USE_W-1:0] bump(input logic [USE_W-1:0] v);
        return (v >= USE_CEIL) ? USE_CEIL : v + 1'b1;
    endfunction

endpackage

@@ src/csre_ram.sv @@
module csre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ src/cache_set_replacement_engine.sv @@
// A transferred request goes through set read and line alignment, then a
// read-modify-write of the set row once the result register is free.
// Requests do not overlap: the single set-row RAM is read, updated and
// written back before the next request is taken.
// Reset: synchronous, active low. After reset a clearing pass writes all
// SETS set rows (64 by default) to zero, with input stall held high.
module cache_set_replacement_engine
    import csre_pkg::*;
#(
    parameter int SETS      = DEF_SETS,
    parameter int WAYS      = DEF_WAYS,
    parameter int LINE_SIZE = DEF_LINE_SIZE
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_req_type,
    input  logic [5:0]  i_set_index,
    input  logic [31:0] i_address,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_hit,
    output logic [1:0]  o_way,
    output logic        o_evicted_valid,
    output logic [31:0] o_evicted_address
);

    localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ROW_W = WAYS * ENT_W;
    // floor(2^32 / LINE_SIZE): quotient estimate is exact or one low
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / LINE_SIZE);
    localparam logic [31:0] LS32  = 32'(LINE_SIZE);

    t_state r_state, n_state;

    logic [1:0]       r_policy;
    logic [SET_W-1:0] r_clr_idx;
    logic [SET_W-1:0] r_set;
    logic             r_fill;
    logic [31:0]      r_addr;
    logic [31:0]      r_q0;
    logic [31:0]      r_line;
    logic             r_out_valid;
    logic             r_hit;
    logic [1:0]       r_way;
    logic             r_ev_valid;
    logic [31:0]      r_ev_addr;

    logic             in_xfer;
    logic             out_free;
    logic             calc_done;
    logic             cfg_wr;
    logic [SET_W-1:0] set_in;
    logic [63:0]      prod;
    logic [31:0]      qd;
    logic [31:0]      rem0;
    logic [31:0]      rem_fix;

    logic             ram_we;
    logic [SET_W-1:0] ram_waddr;
    logic [ROW_W-1:0] ram_wdata;
    logic [SET_W-1:0] ram_raddr;
    logic [ROW_W-1:0] rd_row;
    logic [ROW_W-1:0] new_row;

    logic             v   [WAYS];
    logic [31:0]      la  [WAYS];
    logic [USE_W-1:0] c   [WAYS];
    logic             v2  [WAYS];
    logic [31:0]      la2 [WAYS];
    logic [USE_W-1:0] c2  [WAYS];
    logic             hit_any;
    logic [WAY_W-1:0] hit_way;
    logic [WAY_W-1:0] vic;
    logic             zero_found;
    logic [USE_W-1:0] best;
    logic [USE_W-1:0] top;
    logic             ev_valid;
    logic [31:0]      ev_addr;
    logic [WAY_W-1:0] res_way;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = {30'd0, r_policy};
    assign cfg_wr = psel && penable && pwrite && ((paddr >> 2) == REG_POLICY);

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign set_in   = SET_W'({26'd0, i_set_index} % SETS);

    // Quotient estimate of address / LINE_SIZE
    assign prod = 64'(i_address) * 64'(RECIP);

    // Remainder with one correction step
    assign qd      = r_q0 * LS32;
    assign rem0    = r_addr - qd;
    assign rem_fix = (rem0 >= LS32) ? rem0 - LS32 : rem0;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr_idx == SET_W'(SETS - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (in_xfer) n_state = ST_ALIGN;
            ST_ALIGN: n_state = ST_CALC;
            ST_CALC:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    // FSM outputs: stall, RAM control
    always_comb begin
        o_in_stall = 1'b1;
        calc_done  = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = r_set;
        ram_wdata  = new_row;
        ram_raddr  = r_set;
        unique case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_idx;
                ram_wdata = '0;
            end
            ST_IDLE: begin
                o_in_stall = 1'b0;
                ram_raddr  = set_in;
            end
            ST_ALIGN: begin
            end
            ST_CALC: begin
                calc_done = out_free;
                ram_we    = out_free;
            end
            default: begin
            end
        endcase
    end

    // Set row read, modify
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            v[w]  = rd_row[w*ENT_W + ENT_W - 1];
            la[w] = rd_row[w*ENT_W + USE_W +: ADDR_W];
            c[w]  = rd_row[w*ENT_W +: USE_W];
        end

        // lowest matching way
        hit_any = 1'b0;
        hit_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (v[w] && (la[w] == r_line)) begin
                hit_any = 1'b1;
                hit_way = WAY_W'(w);
            end
        end

        // victim: first zero count, else first largest (FIFO) or smallest
        zero_found = 1'b0;
        vic        = '0;
        best       = (r_policy == POL_FIFO) ? '0 : '1;
        for (int w = 0; w < WAYS; w++) begin
            if (!zero_found) begin
                if (c[w] == '0) begin
                    zero_found = 1'b1;
                    vic        = WAY_W'(w);
                end else if ((r_policy == POL_FIFO) ? (c[w] > best) : (c[w] < best)) begin
                    best = c[w];
                    vic  = WAY_W'(w);
                end
            end
        end

        ev_valid = r_fill && v[vic];
        ev_addr  = ev_valid ? la[vic] : 32'd0;

        // install on fill
        for (int w = 0; w < WAYS; w++) begin
            v2[w]  = v[w];
            la2[w] = la[w];
            c2[w]  = c[w];
        end
        if (r_fill) begin
            v2[vic]  = 1'b1;
            la2[vic] = r_line;
            c2[vic]  = '0;
        end

        // largest count among valid ways
        top = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (v2[w] && (c2[w] > top)) top = c2[w];
        end

        // policy update
        for (int w = 0; w < WAYS; w++) begin
            case (r_policy)
                POL_FIFO: if (v2[w]) c2[w] = bump(c2[w]);
                POL_LFU:  if (v2[w] && (la2[w] == r_line)) c2[w] = bump(c2[w]);
                default:  if (v2[w] && (la2[w] == r_line)) c2[w] = bump(top);
            endcase
        end

        for (int w = 0; w < WAYS; w++) begin
            new_row[w*ENT_W +: ENT_W] = {v2[w], la2[w], c2[w]};
        end

        res_way = r_fill ? vic : hit_way;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_policy    <= POL_FIFO;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) r_policy <= pwdata[1:0];
            if (r_state == ST_CLEAR) r_clr_idx <= r_clr_idx + 1'b1;
            if (calc_done) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_set  <= set_in;
            r_fill <= i_req_type;
            r_addr <= i_address;
            r_q0   <= prod[63:32];
        end
        if (r_state == ST_ALIGN) r_line <= r_addr - rem_fix;
        if (calc_done) begin
            r_hit      <= hit_any;
            r_way      <= 2'(res_way);
            r_ev_valid <= ev_valid;
            r_ev_addr  <= ev_addr;
        end
    end

    csre_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd_row)
    );

    assign o_out_valid       = r_out_valid;
    assign o_hit             = r_hit;
    assign o_way             = r_way;
    assign o_evicted_valid   = r_ev_valid;
    assign o_evicted_address = r_ev_addr;

endmodule

@@ src/csre_checker.sv @@
module csre_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_hit,
    input logic [1:0]  o_way,
    input logic        o_evicted_valid,
    input logic [31:0] o_evicted_address
);

    // Stalled result stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    // Stalled result payload holds
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> ($stable(o_hit) && $stable(o_way)
            && $stable(o_evicted_valid) && $stable(o_evicted_address)))
        else $error("result payload changed while stalled");

    // One request in flight: a transfer is followed by stall
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request taken while another is in flight");

    // No displaced line means a zero address
    a_evict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_evicted_valid) |-> (o_evicted_address == 32'd0))
        else $error("evicted address set without an eviction");

endmodule

bind cache_set_replacement_engine csre_checker u_csre_checker (.*);
